### hdl/kll_pkg.sv
// Shared types, constants and keyword tables for the keyword lexer.
// Used by kll_core, kll_result_fifo and keyword_lexer_byte_stream.
// No dependencies.
`default_nettype none

package kll_pkg;

	localparam int COUNTER_BITS_DEF = 24;
	localparam int FIELD_BITS       = 24;
	localparam int RQ_DEPTH         = 4;
	localparam int RQ_PTR_BITS      = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_BITS      = $clog2(RQ_DEPTH + 1);

	localparam logic [7:0] COMMENT_CHAR_RESET = 8'h3B;
	localparam logic [7:0] CHAR_TAB           = 8'h09;
	localparam logic [7:0] CHAR_NL            = 8'h0A;
	localparam logic [7:0] CHAR_CR            = 8'h0D;
	localparam logic [7:0] CHAR_SPACE         = 8'h20;

	typedef enum logic [3:0] {
		KIND_INVALID = 4'd0,
		KIND_I       = 4'd1,
		KIND_AM      = 4'd2,
		KIND_BORED   = 4'd3,
		KIND_BTW     = 4'd4,
		KIND_BY      = 4'd5,
		KIND_THE     = 4'd6,
		KIND_WAY     = 4'd7,
		KIND_SLEEP   = 4'd8,
		KIND_END     = 4'd9
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_MATCH   = 3'd2,
		MODE_AFTER_B = 3'd3,
		MODE_PENDING = 3'd4
	} mode_t;

	typedef struct packed {
		logic [7:0] input_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [3:0]            token_kind;
		logic [FIELD_BITS-1:0] token_line;
		logic [FIELD_BITS-1:0] token_column;
		logic                  last_of_run;
	} out_item_t;

	// Up to two results produced by one request, handed to the result queue.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} res_pair_t;

	// Number of letters that follow the letters that select a keyword.
	function automatic logic [2:0] tail_len(kind_t k);
		logic [2:0] len;
		case (k)
			KIND_AM:    len = 3'd1;
			KIND_BORED: len = 3'd3;
			KIND_BTW:   len = 3'd1;
			KIND_THE:   len = 3'd2;
			KIND_WAY:   len = 3'd2;
			KIND_SLEEP: len = 3'd4;
			default:    len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] tail_char(kind_t k, logic [2:0] p);
		logic [7:0] c;
		c = 8'h00;
		case (k)
			KIND_AM:    c = "m";
			KIND_BORED: begin
				case (p)
					3'd0:    c = "r";
					3'd1:    c = "e";
					3'd2:    c = "d";
					default: c = 8'h00;
				endcase
			end
			KIND_BTW:   c = "w";
			KIND_THE:   c = (p == 3'd0) ? "h" : "e";
			KIND_WAY:   c = (p == 3'd0) ? "a" : "y";
			KIND_SLEEP: begin
				case (p)
					3'd0:    c = "l";
					3'd1:    c = "e";
					3'd2:    c = "e";
					3'd3:    c = "p";
					default: c = 8'h00;
				endcase
			end
			default:    c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### hdl/kll_core.sv
// Lexer core: input register, scan state, line/column counters and the
// per-request token decision. Depends on kll_pkg.
`default_nettype none

module kll_core #(
	parameter int COUNTER_BITS = kll_pkg::COUNTER_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire kll_pkg::in_item_t   in_data,
	input  wire logic                room,
	output kll_pkg::res_pair_t       push
);

	localparam int CB = COUNTER_BITS;
	localparam int FW = kll_pkg::FIELD_BITS;
	localparam int EW = (CB > FW) ? CB : FW;
	localparam logic [CB-1:0] CNT_MAX  = {CB{1'b1}};
	localparam logic [CB-1:0] LINE_ONE = CB'(1);
	localparam logic [FW-1:0] COL_ONE  = FW'(1);

	logic                valid_s1;
	kll_pkg::in_item_t   item_s1;
	logic                fire;

	logic [7:0]          cc_q;
	kll_pkg::mode_t      mode_q, mode_d;
	kll_pkg::kind_t      kw_q, kw_d;
	logic [2:0]          pos_q, pos_d;
	logic [CB-1:0]       line_q, line_d;
	logic [CB-1:0]       col_q, col_d;
	logic [CB-1:0]       start_q, start_d;

	logic [7:0]          b;
	logic                is_cmt, is_nl, is_blank, is_tok, is_letter, idle_inv;
	logic                tail_hit;
	logic [2:0]          len;
	logic [CB-1:0]       line_inc, col_inc, col_inc2;
	logic [1:0]          cnt;
	kll_pkg::out_item_t  r0, r1;

	function automatic logic [FW-1:0] to_field(logic [CB-1:0] v);
		logic [EW-1:0] t;
		t = EW'(v);
		return t[FW-1:0];
	endfunction

	function automatic kll_pkg::out_item_t mk(kll_pkg::kind_t k, logic [FW-1:0] ln,
		logic [FW-1:0] cl);
		kll_pkg::out_item_t r;
		r.token_kind   = k;
		r.token_line   = ln;
		r.token_column = cl;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	// Input register; it advances whenever the result queue can take two results.
	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= kll_pkg::COMMENT_CHAR_RESET;
		end else if (cfg_we) begin
			cc_q <= cfg_wdata;
		end
	end

	// Byte classification and counter increments shared by both decision blocks.
	assign b         = item_s1.input_byte;
	assign is_cmt    = (b == cc_q);
	assign is_nl     = (b == kll_pkg::CHAR_NL);
	assign is_blank  = (b == kll_pkg::CHAR_TAB) || (b == kll_pkg::CHAR_CR) ||
	                   (b == kll_pkg::CHAR_SPACE);
	assign is_tok    = !is_blank && !is_nl && !is_cmt;
	assign is_letter = (b == "i") || (b == "a") || (b == "b") || (b == "t") ||
	                   (b == "w") || (b == "s");
	assign idle_inv  = is_tok && !is_letter;
	assign len       = kll_pkg::tail_len(kw_q);
	assign tail_hit  = (pos_q < len) && (b == kll_pkg::tail_char(kw_q, pos_q));
	assign line_inc  = (line_q == CNT_MAX) ? line_q : line_q + LINE_ONE;
	assign col_inc   = (col_q == CNT_MAX) ? col_q : col_q + LINE_ONE;
	assign col_inc2  = (col_inc == CNT_MAX) ? col_inc : col_inc + LINE_ONE;

	// Next state.
	always_comb begin
		logic run_idle;
		run_idle = 1'b0;
		mode_d   = mode_q;
		kw_d     = kw_q;
		pos_d    = pos_q;
		line_d   = line_q;
		col_d    = col_q;
		start_d  = start_q;
		if (item_s1.end_of_input) begin
			mode_d = kll_pkg::MODE_IDLE;
			kw_d   = kll_pkg::KIND_INVALID;
			pos_d  = 3'd0;
			line_d = LINE_ONE;
			col_d  = '0;
		end else begin
			unique case (mode_q)
				kll_pkg::MODE_COMMENT: begin
					if (is_nl) begin
						line_d = line_inc;
						col_d  = '0;
						mode_d = kll_pkg::MODE_IDLE;
					end else begin
						col_d = col_inc;
					end
				end
				kll_pkg::MODE_AFTER_B: begin
					col_d = col_inc;
					pos_d = 3'd0;
					priority if (b == "o") begin
						kw_d   = kll_pkg::KIND_BORED;
						mode_d = kll_pkg::MODE_MATCH;
					end else if (b == "t") begin
						kw_d   = kll_pkg::KIND_BTW;
						mode_d = kll_pkg::MODE_MATCH;
					end else if (b == "y") begin
						kw_d   = kll_pkg::KIND_BY;
						mode_d = kll_pkg::MODE_PENDING;
					end else begin
						mode_d = kll_pkg::MODE_IDLE;
					end
				end
				kll_pkg::MODE_MATCH: begin
					col_d = col_inc;
					if (tail_hit) begin
						pos_d = pos_q + 3'd1;
						if ((pos_q + 3'd1) >= len) begin
							mode_d = kll_pkg::MODE_PENDING;
						end
					end else begin
						mode_d = kll_pkg::MODE_IDLE;
					end
				end
				default: run_idle = 1'b1;
			endcase
			// Between tokens, or after a pending keyword; the keyword itself is decided in the results block below.
			if (run_idle) begin
				mode_d = kll_pkg::MODE_IDLE;
				priority if (is_cmt) begin
					col_d  = col_inc;
					mode_d = kll_pkg::MODE_COMMENT;
				end else if (is_nl) begin
					line_d = line_inc;
					col_d  = '0;
				end else if (is_blank) begin
					col_d = col_inc;
				end else begin
					col_d   = col_inc;
					start_d = col_inc;
					pos_d   = 3'd0;
					priority if (b == "i") begin
						kw_d   = kll_pkg::KIND_I;
						mode_d = kll_pkg::MODE_PENDING;
					end else if (b == "a") begin
						kw_d   = kll_pkg::KIND_AM;
						mode_d = kll_pkg::MODE_MATCH;
					end else if (b == "b") begin
						mode_d = kll_pkg::MODE_AFTER_B;
					end else if (b == "t") begin
						kw_d   = kll_pkg::KIND_THE;
						mode_d = kll_pkg::MODE_MATCH;
					end else if (b == "w") begin
						kw_d   = kll_pkg::KIND_WAY;
						mode_d = kll_pkg::MODE_MATCH;
					end else if (b == "s") begin
						kw_d   = kll_pkg::KIND_SLEEP;
						mode_d = kll_pkg::MODE_MATCH;
					end else begin
						mode_d = kll_pkg::MODE_IDLE;
					end
				end
			end
		end
	end

	// Results.
	always_comb begin
		cnt = 2'd0;
		r0  = mk(kll_pkg::KIND_INVALID, to_field(line_q), to_field(start_q));
		r1  = mk(kll_pkg::KIND_END, to_field(line_q), to_field(col_inc));
		if (item_s1.end_of_input) begin
			unique case (mode_q)
				kll_pkg::MODE_COMMENT: begin
					cnt = 2'd1;
					r0  = mk(kll_pkg::KIND_END, to_field(line_inc), COL_ONE);
				end
				kll_pkg::MODE_MATCH, kll_pkg::MODE_AFTER_B: begin
					cnt = 2'd2;
					r1  = mk(kll_pkg::KIND_END, to_field(line_q), to_field(col_inc2));
				end
				kll_pkg::MODE_PENDING: begin
					cnt = 2'd2;
					r0  = mk(kw_q, to_field(line_q), to_field(start_q));
				end
				default: begin
					cnt = 2'd1;
					r0  = mk(kll_pkg::KIND_END, to_field(line_q), to_field(col_inc));
				end
			endcase
		end else begin
			unique case (mode_q)
				kll_pkg::MODE_COMMENT: cnt = 2'd0;
				kll_pkg::MODE_AFTER_B: begin
					if (!((b == "o") || (b == "t") || (b == "y"))) begin
						cnt = 2'd1;
					end
				end
				kll_pkg::MODE_MATCH: begin
					if (!tail_hit) begin
						cnt = 2'd1;
					end
				end
				kll_pkg::MODE_PENDING: begin
					// The byte after a keyword decides it, then is scanned afresh.
					r0  = mk(is_tok ? kll_pkg::KIND_INVALID : kw_q, to_field(line_q),
					         to_field(start_q));
					cnt = idle_inv ? 2'd2 : 2'd1;
					r1  = mk(kll_pkg::KIND_INVALID, to_field(line_q), to_field(col_inc));
				end
				default: begin
					if (idle_inv) begin
						cnt = 2'd1;
						r0  = mk(kll_pkg::KIND_INVALID, to_field(line_q), to_field(col_inc));
					end
				end
			endcase
		end
		r0.last_of_run = (cnt == 2'd1);
		r1.last_of_run = 1'b1;
	end

	assign push.count  = fire ? cnt : 2'd0;
	assign push.first  = r0;
	assign push.second = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kll_pkg::MODE_IDLE;
			kw_q   <= kll_pkg::KIND_INVALID;
			pos_q  <= 3'd0;
			line_q <= LINE_ONE;
			col_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			kw_q   <= kw_d;
			pos_q  <= pos_d;
			line_q <= line_d;
			col_q  <= col_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			start_q <= start_d;
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.end_of_input |=>
			mode_q == kll_pkg::MODE_IDLE && line_q == LINE_ONE && col_q == '0)
		else $error("state not cleared after end request");

	a_match_pos: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == kll_pkg::MODE_MATCH |-> pos_q < kll_pkg::tail_len(kw_q))
		else $error("match position beyond keyword tail");

	a_pair_cause: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |->
			item_s1.end_of_input || mode_q == kll_pkg::MODE_PENDING)
		else $error("two results without end or pending keyword");

endmodule

`default_nettype wire

### hdl/kll_result_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while out_stall is low.
// Depends on kll_pkg.
`default_nettype none

module kll_result_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire kll_pkg::res_pair_t  push,
	output logic                     room,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output kll_pkg::out_item_t       out_data
);

	localparam int PW = kll_pkg::RQ_PTR_BITS;
	localparam int CW = kll_pkg::RQ_CNT_BITS;
	localparam logic [CW-1:0] DEPTH = CW'(kll_pkg::RQ_DEPTH);

	kll_pkg::out_item_t entry_q [kll_pkg::RQ_DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [CW-1:0]      count_q;
	logic               pop;

	assign room      = (count_q <= DEPTH - CW'(2));
	assign out_valid = (count_q != '0);
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign wr_ptr_1  = wr_ptr_q + PW'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> count_q <= DEPTH - CW'(2))
		else $error("result queue written without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH)
		else $error("result queue count out of range");

endmodule

`default_nettype wire

### hdl/keyword_lexer_byte_stream.sv
// Top level of the keyword lexer over a byte stream.
// Instantiates kll_core and kll_result_fifo; depends on kll_pkg.
//
// One request is one source byte or the end marker; the block takes a request
// in every cycle unless it stalls and gives the tokens i, am, bored, btw, by,
// the, way, sleep, INVALID and END with line and start column. A request is
// held in an input register and its zero, one or two tokens are written to a
// four-entry result queue, so the first token of a request passes through both
// before it is offered on the output. The sustained rate is one request per
// cycle while the output keeps pace; the output delivers one token per cycle
// unless stalled, so requests that give two tokens (an end marker after a
// keyword or partial match, or a byte that follows a finished keyword and is
// itself invalid) hold the output longer. The input stalls when the queue holds
// more than two tokens. The comment character register may be written only
// while no request is in flight; after an end marker all scan state and
// counters return to their reset values. Line and column saturate.
`default_nettype none

module keyword_lexer_byte_stream #(
	parameter int COUNTER_BITS = kll_pkg::COUNTER_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire kll_pkg::in_item_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output kll_pkg::out_item_t       out_data
);

	kll_pkg::res_pair_t push;
	logic               room;

	kll_core #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.room     (room),
		.push     (push)
	);

	kll_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
